@@ sv/sltok_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell line tokenizer package
// Shared types, character codes, error codes and register indexes.
// ----------------------------------------------------------------------------
package sltok_pkg;

    localparam int DEF_MAX_TOKEN_LENGTH = 1024;
    localparam int DEF_TOKEN_COUNT_MAX  = 256;

    localparam int CFG_DATA_W  = 11;
    localparam int CFG_COUNT_W = 9;

    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_DQUOTE   = 2'd1;
    localparam logic [1:0] ERR_SQUOTE   = 2'd2;
    localparam logic [1:0] ERR_TOO_MANY = 2'd3;

    localparam logic CFG_TOKEN_LENGTH_LIMIT = 1'b0;
    localparam logic CFG_TOKEN_COUNT_LIMIT  = 1'b1;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_WORD  = 3'd1,
        MODE_OPER  = 3'd2,
        MODE_SQ    = 3'd3,
        MODE_DQ    = 3'd4,
        MODE_DQESC = 3'd5
    } mode_t;

    typedef struct packed {
        logic       close_before;
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       close_after;
        logic [7:0] token_index;
        logic       line_done;
        logic [1:0] error_code;
    } result_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic logic is_oper(input logic [7:0] b);
        return (b == CH_GT) || (b == CH_LT) || (b == CH_AMP) || (b == CH_PIPE);
    endfunction

endpackage

@@ sv/sltok_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell line tokenizer configuration
// Holds the token length and token count limits, clamped to their legal ranges.
// ----------------------------------------------------------------------------
module sltok_cfg
    import sltok_pkg::*;
#(
    parameter int MAX_TOKEN_LENGTH = DEF_MAX_TOKEN_LENGTH,
    parameter int TOKEN_COUNT_MAX  = DEF_TOKEN_COUNT_MAX,
    localparam int LW = $clog2(MAX_TOKEN_LENGTH + 1),
    localparam int TW = $clog2(TOKEN_COUNT_MAX + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [LW-1:0]         len_lim,
    output logic [TW-1:0]         cnt_lim
);

    localparam int LEN_RST = (1024 > MAX_TOKEN_LENGTH) ? MAX_TOKEN_LENGTH : 1024;
    localparam int CNT_RST = (256 > TOKEN_COUNT_MAX) ? TOKEN_COUNT_MAX : 256;
    localparam int LXW = (LW > CFG_DATA_W) ? LW : CFG_DATA_W;
    localparam int CXW = (TW > CFG_COUNT_W) ? TW : CFG_COUNT_W;

    logic [LW-1:0]  len_lim_reg;
    logic [LW-1:0]  len_lim_next;
    logic [TW-1:0]  cnt_lim_reg;
    logic [TW-1:0]  cnt_lim_next;
    logic [LXW-1:0] len_ext;
    logic [CXW-1:0] cnt_ext;

    assign len_ext = LXW'(cfg_data);
    assign cnt_ext = CXW'(cfg_data[CFG_COUNT_W-1:0]);

    always_comb
    begin
        len_lim_next = len_lim_reg;
        cnt_lim_next = cnt_lim_reg;
        if (cfg_valid && (cfg_index == CFG_TOKEN_LENGTH_LIMIT))
        begin
            if (len_ext > LXW'(MAX_TOKEN_LENGTH))
                len_lim_next = LW'(MAX_TOKEN_LENGTH);
            else if (len_ext < LXW'(2))
                len_lim_next = LW'(2);
            else
                len_lim_next = LW'(len_ext);
        end
        if (cfg_valid && (cfg_index == CFG_TOKEN_COUNT_LIMIT))
        begin
            if (cnt_ext > CXW'(TOKEN_COUNT_MAX))
                cnt_lim_next = TW'(TOKEN_COUNT_MAX);
            else if (cnt_ext < CXW'(1))
                cnt_lim_next = TW'(1);
            else
                cnt_lim_next = TW'(cnt_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_lim_reg <= LW'(LEN_RST);
            cnt_lim_reg <= TW'(CNT_RST);
        end
        else
        begin
            len_lim_reg <= len_lim_next;
            cnt_lim_reg <= cnt_lim_next;
        end
    end

    assign len_lim = len_lim_reg;
    assign cnt_lim = cnt_lim_reg;

endmodule

@@ sv/sltok_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell line tokenizer scanner
// Scan state registers and the per-byte decision logic that forms one result.
// ----------------------------------------------------------------------------
module sltok_scan
    import sltok_pkg::*;
#(
    parameter int MAX_TOKEN_LENGTH = DEF_MAX_TOKEN_LENGTH,
    parameter int TOKEN_COUNT_MAX  = DEF_TOKEN_COUNT_MAX,
    localparam int LW = $clog2(MAX_TOKEN_LENGTH + 1),
    localparam int TW = $clog2(TOKEN_COUNT_MAX + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    char_in,
    input  logic          end_of_line,
    input  logic [LW-1:0] len_lim,
    input  logic [TW-1:0] cnt_lim,
    output result_t       result
);

    mode_t         mode_reg;
    mode_t         mode_next;
    logic [7:0]    pop_reg;
    logic [7:0]    pop_next;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic [TW-1:0] tc_reg;
    logic [TW-1:0] tc_next;
    logic [1:0]    err_reg;
    logic [1:0]    err_next;

    logic          eol;
    logic          sp;
    logic          op;
    logic          exc;
    logic          exc_inc;
    logic [TW-1:0] tc_inc;
    logic [LW-1:0] len_inc;
    logic          len_full;
    logic          len_q_full;
    mode_t         st_mode;
    logic [LW-1:0] st_len;
    logic          st_emit;
    logic [TW+7:0] idx_wide;

    assign eol        = end_of_line || (char_in == CH_NUL);
    assign sp         = is_space(char_in);
    assign op         = is_oper(char_in);
    assign exc        = tc_reg >= cnt_lim;
    assign tc_inc     = tc_reg + TW'(1);
    assign exc_inc    = tc_inc >= cnt_lim;
    assign len_inc    = len_reg + LW'(1);
    assign len_full   = ({1'b0, len_reg} + (LW+1)'(1)) >= {1'b0, len_lim};
    assign len_q_full = ({1'b0, len_reg} + (LW+1)'(2)) >= {1'b0, len_lim};

    // How a token opens on this byte.
    always_comb
    begin
        st_mode = MODE_WORD;
        st_len  = LW'(1);
        st_emit = 1'b1;
        if (sp)
        begin
            st_mode = MODE_IDLE;
            st_len  = '0;
            st_emit = 1'b0;
        end
        else if (char_in == CH_DQ)
        begin
            st_mode = MODE_DQ;
            st_len  = '0;
            st_emit = 1'b0;
        end
        else if (char_in == CH_SQ)
        begin
            st_mode = MODE_SQ;
            st_len  = '0;
            st_emit = 1'b0;
        end
        else if (op)
        begin
            st_mode = MODE_OPER;
            st_len  = '0;
        end
    end

    always_comb
    begin
        logic idx_hold;
        logic do_cts;
        logic do_start;
        logic start_exc;
        logic [1:0] q_code;
        logic do_quoted;
        logic do_qclose;

        mode_next = mode_reg;
        pop_next  = pop_reg;
        len_next  = len_reg;
        tc_next   = tc_reg;
        err_next  = err_reg;
        result    = '0;
        idx_hold  = 1'b0;
        do_cts    = 1'b0;
        do_start  = 1'b0;
        start_exc = exc;
        q_code    = ERR_DQUOTE;
        do_quoted = 1'b0;
        do_qclose = 1'b0;

        if (eol)
        begin
            if (err_reg == ERR_NONE)
            begin
                unique case (mode_reg)
                    MODE_WORD, MODE_OPER:
                    begin
                        if (exc)
                            err_next = ERR_TOO_MANY;
                        else
                        begin
                            result.close_before = 1'b1;
                            tc_next = tc_inc;
                        end
                    end
                    MODE_SQ:
                        err_next = ERR_SQUOTE;
                    MODE_DQ, MODE_DQESC:
                        err_next = ERR_DQUOTE;
                    default:
                    begin
                    end
                endcase
            end
            result.line_done = 1'b1;
        end
        else if (err_reg == ERR_NONE)
        begin
            unique case (mode_reg)
                MODE_WORD:
                begin
                    if (!sp && !op && !len_full)
                    begin
                        len_next = len_inc;
                        if (!exc)
                        begin
                            result.byte_valid = 1'b1;
                            result.data_byte  = char_in;
                        end
                    end
                    else
                        do_cts = 1'b1;
                end
                MODE_OPER:
                begin
                    if (char_in == pop_reg)
                    begin
                        idx_hold  = 1'b1;
                        do_qclose = 1'b1;
                    end
                    else
                        do_cts = 1'b1;
                end
                MODE_SQ:
                begin
                    q_code = ERR_SQUOTE;
                    if (char_in == CH_SQ)
                    begin
                        idx_hold  = 1'b1;
                        do_qclose = 1'b1;
                    end
                    else
                        do_quoted = 1'b1;
                end
                MODE_DQ:
                begin
                    if (char_in == CH_DQ)
                    begin
                        idx_hold  = 1'b1;
                        do_qclose = 1'b1;
                    end
                    else if (char_in == CH_BSL)
                        mode_next = MODE_DQESC;
                    else
                        do_quoted = 1'b1;
                end
                MODE_DQESC:
                begin
                    mode_next = MODE_DQ;
                    do_quoted = 1'b1;
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    do_start  = 1'b1;
                end
            endcase

            if (do_qclose)
            begin
                if (exc)
                begin
                    err_next  = ERR_TOO_MANY;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    if (mode_reg == MODE_OPER)
                    begin
                        result.byte_valid = 1'b1;
                        result.data_byte  = char_in;
                    end
                    result.close_after = 1'b1;
                    tc_next   = tc_inc;
                    mode_next = MODE_IDLE;
                    len_next  = '0;
                    pop_next  = '0;
                end
            end

            if (do_quoted)
            begin
                if (len_q_full)
                begin
                    err_next  = q_code;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    len_next = len_inc;
                    if (!exc)
                    begin
                        result.byte_valid = 1'b1;
                        result.data_byte  = char_in;
                    end
                end
            end

            if (do_cts)
            begin
                if (exc)
                begin
                    err_next  = ERR_TOO_MANY;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    result.close_before = 1'b1;
                    tc_next   = tc_inc;
                    mode_next = MODE_IDLE;
                    len_next  = '0;
                    pop_next  = '0;
                    do_start  = 1'b1;
                    start_exc = exc_inc;
                end
            end

            if (do_start)
            begin
                mode_next = st_mode;
                len_next  = st_len;
                if (st_mode == MODE_OPER)
                    pop_next = char_in;
                if (st_emit && !start_exc)
                begin
                    result.byte_valid = 1'b1;
                    result.data_byte  = char_in;
                end
            end
        end

        idx_wide = (TW+8)'(idx_hold ? tc_reg : tc_next);
        result.token_index = idx_wide[7:0];
        result.error_code  = err_next;
        if (err_next != ERR_NONE)
        begin
            result.close_before = 1'b0;
            result.byte_valid   = 1'b0;
            result.data_byte    = '0;
            result.close_after  = 1'b0;
        end

        if (eol)
        begin
            mode_next = MODE_IDLE;
            pop_next  = '0;
            len_next  = '0;
            tc_next   = '0;
            err_next  = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            pop_reg  <= '0;
            len_reg  <= '0;
            tc_reg   <= '0;
            err_reg  <= ERR_NONE;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            pop_reg  <= pop_next;
            len_reg  <= len_next;
            tc_reg   <= tc_next;
            err_reg  <= err_next;
        end
    end

endmodule

@@ sv/shell_line_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell line tokenizer
// Splits a command line, one byte per item, into words, operators and quoted
// tokens, and streams each token's bytes out with open and close marks.
//
// The slave stream takes one byte per item in s_axis_tdata; s_axis_tlast, or
// a zero byte, ends the line. Every input item gives exactly one result item
// on the master stream, which carries the close marks, the appended byte, the
// token index and the line's error code in m_axis_tdata, and the end of the
// line in m_axis_tlast. Limits are written through the cfg port, index 0 for
// the token length limit and index 1 for the token count limit; cfg_ready is
// always high.
// An item passes an input register and then the scan logic into the result
// register, so its result is registered once the result register is free.
// One item is taken in every cycle while the receiver does not stall.
// Reset empties both registers, clears the scan state and loads the limits
// with 1024 and 256. While the receiver stalls, the result register holds,
// one more item waits in the input register, and s_axis_tready then drops.
// ----------------------------------------------------------------------------
module shell_line_tokenizer
    import sltok_pkg::*;
#(
    parameter int MAX_TOKEN_LENGTH = DEF_MAX_TOKEN_LENGTH,
    parameter int TOKEN_COUNT_MAX  = DEF_TOKEN_COUNT_MAX
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // char_in
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // close_before, byte_valid, data_byte, close_after, token_index,
    // error_code, zero fill
    output logic [23:0]           m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LW = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam int TW = $clog2(TOKEN_COUNT_MAX + 1);

    logic          in_valid_reg;
    logic          in_valid_next;
    logic [7:0]    in_char_reg;
    logic          in_last_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    result_t       out_data_reg;
    result_t       res;
    logic          adv;
    logic          take;
    logic [LW-1:0] len_lim;
    logic [TW-1:0] cnt_lim;

    assign cfg_ready     = 1'b1;
    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign take          = s_axis_tvalid && s_axis_tready;

    sltok_cfg #(
        .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH),
        .TOKEN_COUNT_MAX (TOKEN_COUNT_MAX)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid && cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .len_lim  (len_lim),
        .cnt_lim  (cnt_lim)
    );

    sltok_scan #(
        .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH),
        .TOKEN_COUNT_MAX (TOKEN_COUNT_MAX)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (adv),
        .char_in    (in_char_reg),
        .end_of_line(in_last_reg),
        .len_lim    (len_lim),
        .cnt_lim    (cnt_lim),
        .result     (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (adv)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (adv)
            out_data_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_data_reg.line_done;
    assign m_axis_tdata  = {3'b000,
                            out_data_reg.error_code,
                            out_data_reg.token_index,
                            out_data_reg.close_after,
                            out_data_reg.data_byte,
                            out_data_reg.byte_valid,
                            out_data_reg.close_before};

    a_error_no_marks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.error_code != ERR_NONE) |->
            !(out_data_reg.close_before || out_data_reg.byte_valid
              || out_data_reg.close_after))
        else $error("Error result carries token marks or a byte.");

    a_close_once: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.close_before && out_data_reg.close_after))
        else $error("Result closes a token both before and after its byte.");

    a_byte_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.byte_valid |-> (out_data_reg.data_byte != CH_NUL))
        else $error("A zero byte was appended to a token.");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("Input stalled while the result register is empty.");

endmodule

@@ sim/tb_shell_line_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell line tokenizer testbench
// Feeds command lines into the tokenizer one byte per item and checks every
// result item against a cycle-free scanner model here or a typed table row.
// A short table of hand-picked lines comes first, then random lines of words,
// operators and quoted strings mixed with noise, under a sweep of length and
// count limits that includes the clamped extremes. Both streams idle at
// random; each mismatch is counted and the first 30 are reported on one line.
// ----------------------------------------------------------------------------
module tb_shell_line_tokenizer;
    import sltok_pkg::*;

    typedef struct {
        logic [7:0] ch;
        logic       eol;
    } line_item_t;

    typedef struct {
        logic [7:0] ch;
        logic       eol;
        logic       typed;
        result_t    want;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic                  row_typed;
    result_t               row_want;

    result_t     token_results_due [$];
    line_item_t  cur_line [$];
    dir_row_t    dir_tab [27];
    logic [7:0]  op_chars [4] = '{CH_GT, CH_LT, CH_AMP, CH_PIPE};

    int          errors = 0;
    int          items_sent = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    // Scanner model state and limit registers.
    mode_t       scan_st = MODE_IDLE;
    logic [7:0]  pend_op = 8'h00;
    int unsigned tok_len = 0;
    int unsigned n_closed = 0;
    logic [1:0]  line_err = ERR_NONE;
    int unsigned len_reg = DEF_MAX_TOKEN_LENGTH;
    int unsigned cnt_reg = DEF_TOKEN_COUNT_MAX;
    logic        cl_before;
    logic        app_valid;
    logic [7:0]  app_byte;
    logic        cl_after;

    shell_line_tokenizer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned len_cap();
        int unsigned v;
        v = len_reg;
        if (v > DEF_MAX_TOKEN_LENGTH)
        begin
            v = DEF_MAX_TOKEN_LENGTH;
        end
        if (v < 2)
        begin
            v = 2;
        end
        return v;
    endfunction

    function automatic int unsigned cnt_cap();
        int unsigned v;
        v = cnt_reg;
        if (v > DEF_TOKEN_COUNT_MAX)
        begin
            v = DEF_TOKEN_COUNT_MAX;
        end
        if (v < 1)
        begin
            v = 1;
        end
        return v;
    endfunction

    function automatic bit blank_char(input logic [7:0] b);
        case (b)
            8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, CH_SPACE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit operator_char(input logic [7:0] b);
        case (b)
            CH_GT, CH_LT, CH_AMP, CH_PIPE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit over_count();
        return n_closed >= cnt_cap();
    endfunction

    function automatic void fail_line(input logic [1:0] code);
        line_err = code;
        scan_st  = MODE_IDLE;
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        if (!over_count())
        begin
            app_valid = 1'b1;
            app_byte  = b;
        end
    endfunction

    function automatic bit end_token();
        if (over_count())
        begin
            fail_line(ERR_TOO_MANY);
            return 1'b0;
        end
        n_closed++;
        scan_st = MODE_IDLE;
        tok_len = 0;
        pend_op = 8'h00;
        return 1'b1;
    endfunction

    function automatic void open_token(input logic [7:0] b);
        if (blank_char(b))
        begin
            return;
        end
        tok_len = 0;
        if (b == CH_DQ)
        begin
            scan_st = MODE_DQ;
        end
        else if (b == CH_SQ)
        begin
            scan_st = MODE_SQ;
        end
        else if (operator_char(b))
        begin
            scan_st = MODE_OPER;
            pend_op = b;
            put_byte(b);
        end
        else
        begin
            scan_st = MODE_WORD;
            tok_len = 1;
            put_byte(b);
        end
    endfunction

    function automatic void add_quoted(input logic [7:0] b, input logic [1:0] code);
        if (tok_len + 1 >= len_cap() - 1)
        begin
            fail_line(code);
            return;
        end
        tok_len++;
        put_byte(b);
    endfunction

    function automatic void split_and_open(input logic [7:0] b);
        if (end_token())
        begin
            cl_before = 1'b1;
            open_token(b);
        end
    endfunction

    function automatic result_t predict_token_step(input logic [7:0] b, input logic last_flag);
        result_t     r;
        bit          hold_idx;
        int unsigned idx;
        bit          done;
        hold_idx  = 1'b0;
        idx       = 0;
        done      = last_flag || (b == CH_NUL);
        cl_before = 1'b0;
        app_valid = 1'b0;
        app_byte  = 8'h00;
        cl_after  = 1'b0;
        if (done)
        begin
            if (line_err == ERR_NONE)
            begin
                case (scan_st)
                    MODE_WORD, MODE_OPER:
                    begin
                        if (end_token())
                        begin
                            cl_before = 1'b1;
                        end
                    end
                    MODE_SQ: fail_line(ERR_SQUOTE);
                    MODE_DQ, MODE_DQESC: fail_line(ERR_DQUOTE);
                    default: ;
                endcase
            end
        end
        else if (line_err == ERR_NONE)
        begin
            case (scan_st)
                MODE_WORD:
                begin
                    if (!blank_char(b) && !operator_char(b))
                    begin
                        if (tok_len >= len_cap() - 1)
                        begin
                            split_and_open(b);
                        end
                        else
                        begin
                            tok_len++;
                            put_byte(b);
                        end
                    end
                    else
                    begin
                        split_and_open(b);
                    end
                end
                MODE_OPER:
                begin
                    if (b == pend_op)
                    begin
                        put_byte(b);
                        idx      = n_closed;
                        hold_idx = 1'b1;
                        if (end_token())
                        begin
                            cl_after = 1'b1;
                        end
                        else
                        begin
                            app_valid = 1'b0;
                        end
                    end
                    else
                    begin
                        split_and_open(b);
                    end
                end
                MODE_SQ:
                begin
                    if (b == CH_SQ)
                    begin
                        idx      = n_closed;
                        hold_idx = 1'b1;
                        if (end_token())
                        begin
                            cl_after = 1'b1;
                        end
                    end
                    else
                    begin
                        add_quoted(b, ERR_SQUOTE);
                    end
                end
                MODE_DQ:
                begin
                    if (b == CH_DQ)
                    begin
                        idx      = n_closed;
                        hold_idx = 1'b1;
                        if (end_token())
                        begin
                            cl_after = 1'b1;
                        end
                    end
                    else if (b == CH_BSL)
                    begin
                        scan_st = MODE_DQESC;
                    end
                    else
                    begin
                        add_quoted(b, ERR_DQUOTE);
                    end
                end
                MODE_DQESC:
                begin
                    scan_st = MODE_DQ;
                    add_quoted(b, ERR_DQUOTE);
                end
                default:
                begin
                    scan_st = MODE_IDLE;
                    open_token(b);
                end
            endcase
        end
        if (!hold_idx)
        begin
            idx = n_closed;
        end
        if (line_err != ERR_NONE)
        begin
            cl_before = 1'b0;
            app_valid = 1'b0;
            app_byte  = 8'h00;
            cl_after  = 1'b0;
        end
        r.close_before = cl_before;
        r.byte_valid   = app_valid;
        r.data_byte    = app_byte;
        r.close_after  = cl_after;
        r.token_index  = idx[7:0];
        r.line_done    = done;
        r.error_code   = line_err;
        if (done)
        begin
            scan_st  = MODE_IDLE;
            pend_op  = 8'h00;
            tok_len  = 0;
            n_closed = 0;
            line_err = ERR_NONE;
        end
        return r;
    endfunction

    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < 30)
        begin
            $display("%0t ns: %s mismatch, got %0d, want %0d", $time, what, got, want);
        end
        errors++;
    endtask

    always @(posedge clk)
    begin : scoreboard
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.close_before = m_axis_tdata[0];
                got.byte_valid   = m_axis_tdata[1];
                got.data_byte    = m_axis_tdata[9:2];
                got.close_after  = m_axis_tdata[10];
                got.token_index  = m_axis_tdata[18:11];
                got.error_code   = m_axis_tdata[20:19];
                got.line_done    = m_axis_tlast;
                if (token_results_due.size() == 0)
                begin
                    report_mismatch("result with no item due", 1, 0);
                end
                else
                begin
                    want = token_results_due.pop_front();
                    if (got.close_before != want.close_before)
                        report_mismatch("close_before", got.close_before, want.close_before);
                    if (got.byte_valid != want.byte_valid)
                        report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
                    if (got.data_byte != want.data_byte)
                        report_mismatch("data_byte", got.data_byte, want.data_byte);
                    if (got.close_after != want.close_after)
                        report_mismatch("close_after", got.close_after, want.close_after);
                    if (got.token_index != want.token_index)
                        report_mismatch("token_index", got.token_index, want.token_index);
                    if (got.line_done != want.line_done)
                        report_mismatch("line_done", got.line_done, want.line_done);
                    if (got.error_code != want.error_code)
                        report_mismatch("error_code", got.error_code, want.error_code);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = predict_token_step(s_axis_tdata, s_axis_tlast);
                token_results_due.push_back(row_typed ? row_want : want);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TOKEN_LENGTH_LIMIT)
                begin
                    len_reg = cfg_data;
                end
                else
                begin
                    cnt_reg = cfg_data[CFG_COUNT_W-1:0];
                end
            end
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < recv_stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat (idle_len()) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_char(input logic [7:0] ch, input logic eol, input logic typed,
                             input result_t want);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? idle_len() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= eol;
        row_typed     <= typed;
        row_want      <= want;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (token_results_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic compose_line();
        int unsigned lim_len;
        int unsigned lim_cnt;
        int unsigned n_tok;
        int unsigned n;
        int unsigned k;
        int unsigned j;
        int          kind;
        logic [7:0]  c;
        logic [7:0]  q;
        lim_len = len_cap();
        lim_cnt = cnt_cap();
        cur_line.delete();
        n_tok = $urandom_range(0, (lim_cnt < 6) ? lim_cnt + 1 : 6);
        for (k = 0; k < n_tok; k++)
        begin
            if (k == 0)
                n = $urandom_range(0, 1);
            else
                n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 2);
            repeat (n)
            begin
                c = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 13)) : CH_SPACE;
                cur_line.push_back('{c, 1'b0});
            end
            kind = $urandom_range(0, 9);
            if (kind < 4)
            begin
                if (lim_len <= 24 && $urandom_range(0, 3) == 0)
                    n = $urandom_range(1, lim_len + 1);
                else
                    n = $urandom_range(1, 8);
                repeat (n)
                begin
                    case ($urandom_range(0, 11))
                        0: c = CH_SQ;
                        1: c = CH_DQ;
                        2: c = CH_BSL;
                        default:
                            do c = 8'($urandom_range(1, 255));
                            while (blank_char(c) || operator_char(c));
                    endcase
                    cur_line.push_back('{c, 1'b0});
                end
            end
            else if (kind < 6)
            begin
                c = op_chars[$urandom_range(0, 3)];
                cur_line.push_back('{c, 1'b0});
                if ($urandom_range(0, 1) == 1)
                    cur_line.push_back('{c, 1'b0});
            end
            else if (kind < 9)
            begin
                q = (kind == 6) ? CH_SQ : CH_DQ;
                cur_line.push_back('{q, 1'b0});
                n = $urandom_range(0, (lim_len < 8) ? lim_len : 8);
                for (j = 0; j < n; j++)
                begin
                    if (q == CH_DQ && $urandom_range(0, 4) == 0)
                    begin
                        cur_line.push_back('{CH_BSL, 1'b0});
                        cur_line.push_back('{8'($urandom_range(1, 255)), 1'b0});
                    end
                    else
                    begin
                        do c = 8'($urandom_range(1, 255));
                        while (c == q || (q == CH_DQ && c == CH_BSL));
                        cur_line.push_back('{c, 1'b0});
                    end
                end
                if ($urandom_range(0, 11) != 0)
                    cur_line.push_back('{q, 1'b0});
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    cur_line.push_back('{8'($urandom_range(1, 255)), 1'b0});
            end
        end
        if ($urandom_range(0, 3) == 0)
            cur_line.push_back('{CH_NUL, 1'b0});
        else
            cur_line.push_back('{8'($urandom_range(0, 255)), 1'b1});
    endtask

    initial
    begin
        #20000000;
        $display("[shell_line_tokenizer] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] phase_len [8];
        logic [CFG_DATA_W-1:0] phase_cnt [8];
        int                    idle_mix [4];
        int                    p;
        int                    k;
        int                    start_count;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_TOKEN_LENGTH_LIMIT;
        cfg_data      = '0;
        row_typed     = 1'b0;
        row_want      = '0;

        phase_len = '{11'd2, 11'd0, 11'd2047, 11'd3, 11'd1024, 11'd5, 11'd9, 11'd17};
        phase_cnt = '{11'd1, 11'd0, 11'd2047, 11'd2, 11'd256, 11'd3, 11'd4, 11'd8};
        phase_len[7] = 11'($urandom_range(2, 40));
        phase_cnt[7] = 11'($urandom_range(1, 12));
        idle_mix  = '{0, 15, 40, 5};

        dir_tab[0]  = '{8'h61, 1'b0, 1'b1, '{1'b0, 1'b1, 8'h61, 1'b0, 8'd0, 1'b0, ERR_NONE}};
        dir_tab[1]  = '{8'hFF, 1'b0, 1'b1, '{1'b0, 1'b1, 8'hFF, 1'b0, 8'd0, 1'b0, ERR_NONE}};
        dir_tab[2]  = '{CH_SPACE, 1'b0, 1'b1,
                        '{1'b1, 1'b0, 8'h00, 1'b0, 8'd1, 1'b0, ERR_NONE}};
        dir_tab[3]  = '{CH_GT, 1'b0, 1'b0, '0};
        dir_tab[4]  = '{CH_GT, 1'b0, 1'b0, '0};
        dir_tab[5]  = '{CH_LT, 1'b0, 1'b0, '0};
        dir_tab[6]  = '{CH_AMP, 1'b0, 1'b0, '0};
        dir_tab[7]  = '{CH_PIPE, 1'b0, 1'b0, '0};
        dir_tab[8]  = '{CH_PIPE, 1'b0, 1'b0, '0};
        dir_tab[9]  = '{CH_TAB, 1'b0, 1'b0, '0};
        dir_tab[10] = '{CH_DQ, 1'b0, 1'b0, '0};
        dir_tab[11] = '{8'h71, 1'b0, 1'b0, '0};
        dir_tab[12] = '{CH_BSL, 1'b0, 1'b0, '0};
        dir_tab[13] = '{CH_DQ, 1'b0, 1'b0, '0};
        dir_tab[14] = '{CH_DQ, 1'b0, 1'b0, '0};
        dir_tab[15] = '{CH_SQ, 1'b0, 1'b0, '0};
        dir_tab[16] = '{CH_SQ, 1'b0, 1'b0, '0};
        dir_tab[17] = '{CH_SQ, 1'b0, 1'b0, '0};
        dir_tab[18] = '{CH_BSL, 1'b0, 1'b0, '0};
        dir_tab[19] = '{CH_SQ, 1'b0, 1'b0, '0};
        dir_tab[20] = '{8'h7A, 1'b1, 1'b0, '0};
        dir_tab[21] = '{CH_SQ, 1'b0, 1'b0, '0};
        dir_tab[22] = '{8'h62, 1'b0, 1'b0, '0};
        dir_tab[23] = '{CH_NUL, 1'b0, 1'b1,
                        '{1'b0, 1'b0, 8'h00, 1'b0, 8'd0, 1'b1, ERR_SQUOTE}};
        dir_tab[24] = '{CH_DQ, 1'b0, 1'b0, '0};
        dir_tab[25] = '{CH_BSL, 1'b0, 1'b0, '0};
        dir_tab[26] = '{8'h80, 1'b1, 1'b1,
                        '{1'b0, 1'b0, 8'h00, 1'b0, 8'd0, 1'b1, ERR_DQUOTE}};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct  = 20;
        recv_stall_pct = 20;
        foreach (dir_tab[i])
        begin
            send_char(dir_tab[i].ch, dir_tab[i].eol, dir_tab[i].typed, dir_tab[i].want);
        end
        drain_results();

        for (p = 0; p < 8; p++)
        begin
            write_limit(CFG_TOKEN_LENGTH_LIMIT, phase_len[p]);
            write_limit(CFG_TOKEN_COUNT_LIMIT, phase_cnt[p]);
            if (p == 4)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            else
            begin
                send_idle_pct  = idle_mix[p % 4];
                recv_stall_pct = idle_mix[(p + 1) % 4];
            end

            // A run of alternating operators overruns the full token count
            // and wraps the token index.
            if (p == 2)
            begin
                for (k = 0; k < 258; k++)
                begin
                    send_char(op_chars[k % 4], 1'b0, 1'b0, '0);
                end
                send_char(8'h41, 1'b1, 1'b0, '0);
                drain_results();
            end

            start_count = items_sent;
            while (items_sent - start_count < 195)
            begin
                compose_line();
                foreach (cur_line[i])
                begin
                    send_char(cur_line[i].ch, cur_line[i].eol, 1'b0, '0);
                end
                if ($urandom_range(0, 14) == 0)
                begin
                    drain_results();
                end
            end
            drain_results();
        end

        repeat (10) @(posedge clk);
        if (errors == 0)
        begin
            $display("[shell_line_tokenizer] OK");
        end
        else
        begin
            $display("[shell_line_tokenizer] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/sltok_pkg.sv
sv/sltok_cfg.sv
sv/sltok_scan.sv
sv/shell_line_tokenizer.sv
sim/tb_shell_line_tokenizer.sv
